FILE: rtl/assert_macros.svh
// Assertion macros for the RTL of the PID position controller, included by the top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge of clk, off while rst_n is low
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never hold on a rising edge of clk, off while rst_n is low
`define ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

FILE: rtl/pidpc_pkg.sv
// Package for the PID position controller: register codes, limits and shared types.
`timescale 1ns / 1ps

package pidpc_pkg;

    // Default width of the circular position scale
    localparam int POSITION_BITS_DEF = 12;

    // Configuration register indexes
    localparam int CFG_INDEX_W = 3;
    localparam logic [CFG_INDEX_W-1:0] REG_GAIN_P     = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_GAIN_I     = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_GAIN_D     = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_TARGET_POS = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_MIN_SPEED  = 3'd4;

    // Fixed field widths
    localparam int GAIN_W  = 8;
    localparam int INT_W   = 18;
    localparam int DRIVE_W = 19;

    // Control limits
    localparam int DEADBAND_LIMIT = 5;
    localparam int INT_RESET_ERR  = 32'h200;
    localparam int INT_MAX        = 65535;
    localparam int SUM_MAX        = 8388607;
    localparam int SUM_MIN        = -8388608;
    localparam int SPEED_BIAS     = 15;
    localparam int DRIVE_SHIFT    = 6;
    localparam int INT_SHIFT      = 4;

    // Gain and speed settings handed to the datapath
    typedef struct packed {
        logic [GAIN_W-1:0] gain_p;
        logic [GAIN_W-1:0] gain_i;
        logic [GAIN_W-1:0] gain_d;
        logic [GAIN_W-1:0] min_speed;
    } pidpc_gains_t;

endpackage

FILE: rtl/pidpc_core.sv
// PID datapath: error fold, deadband, integral update, P/I/D sum and drive scaling.
`timescale 1ns / 1ps

module pidpc_core #(
    parameter int POSITION_BITS = pidpc_pkg::POSITION_BITS_DEF
) (
    input  logic [POSITION_BITS-1:0]             position,
    input  logic [POSITION_BITS-1:0]             target,
    input  pidpc_pkg::pidpc_gains_t              gains,
    input  logic signed [pidpc_pkg::INT_W-1:0]   integral,
    input  logic signed [POSITION_BITS:0]        last_err,
    output logic signed [pidpc_pkg::INT_W-1:0]   integral_next,
    output logic signed [POSITION_BITS:0]        last_err_next,
    output logic signed [pidpc_pkg::DRIVE_W-1:0] drive,
    output logic                                 deadband
);

    localparam int ERR_W  = POSITION_BITS + 1;
    localparam int DIFF_W = POSITION_BITS + 2;
    localparam int SUM_W  = (POSITION_BITS + 13 > 25) ? POSITION_BITS + 13 : 25;
    localparam int IACC_W = pidpc_pkg::INT_W + 2;
    localparam int IB_W   = pidpc_pkg::INT_W - pidpc_pkg::INT_SHIFT;
    localparam int SH_W   = 24 - pidpc_pkg::DRIVE_SHIFT;
    localparam logic signed [DIFF_W-1:0] HALF  =
        signed'(DIFF_W'(1) << (POSITION_BITS - 1));
    localparam logic signed [DIFF_W-1:0] SCALE =
        signed'(DIFF_W'(1) << POSITION_BITS);

    logic signed [DIFF_W-1:0] err_raw;
    logic signed [DIFF_W-1:0] err_fold;
    logic signed [ERR_W-1:0]  err;
    logic signed [31:0]       err32;
    logic signed [ERR_W-1:0]  err_half;
    logic signed [IACC_W-1:0] int_acc;
    logic signed [pidpc_pkg::INT_W-1:0] int_new;
    logic signed [IB_W-1:0]   int_base;
    logic signed [DIFF_W-1:0] err_delta;
    logic signed [SUM_W-1:0]  p_term;
    logic signed [SUM_W-1:0]  i_term;
    logic signed [SUM_W-1:0]  d_term;
    logic signed [SUM_W-1:0]  sum;
    logic signed [23:0]       sum_sat;
    logic signed [SH_W-1:0]   sum_shift;
    logic signed [9:0]        speed_ofs;

    // Error folded onto the circular scale, +-half kept as is
    always_comb
    begin
        err_raw = signed'({2'b00, position}) - signed'({2'b00, target});
        if (err_raw > HALF)
        begin
            err_fold = err_raw - SCALE;
        end
        else if (err_raw < -HALF)
        begin
            err_fold = err_raw + SCALE;
        end
        else
        begin
            err_fold = err_raw;
        end
        err   = err_fold[ERR_W-1:0];
        err32 = 32'(err);
    end

    assign deadband = (err32 <= pidpc_pkg::DEADBAND_LIMIT) &&
                      (err32 >= -pidpc_pkg::DEADBAND_LIMIT);

    // Integral: add half the error, drop on large error, clamp
    always_comb
    begin
        err_half = err >>> 1;
        int_acc  = IACC_W'(integral) + IACC_W'(err_half);
        if ((err32 > pidpc_pkg::INT_RESET_ERR) || (err32 < -pidpc_pkg::INT_RESET_ERR))
        begin
            int_new = '0;
        end
        else if (int_acc > IACC_W'(pidpc_pkg::INT_MAX))
        begin
            int_new = pidpc_pkg::INT_W'(pidpc_pkg::INT_MAX);
        end
        else if (int_acc < -IACC_W'(pidpc_pkg::INT_MAX))
        begin
            int_new = pidpc_pkg::INT_W'(-pidpc_pkg::INT_MAX);
        end
        else
        begin
            int_new = int_acc[pidpc_pkg::INT_W-1:0];
        end
        int_base = int_new[pidpc_pkg::INT_W-1:pidpc_pkg::INT_SHIFT];
    end

    // Three gain products and their sum
    always_comb
    begin
        err_delta = DIFF_W'(err) - DIFF_W'(last_err);
        p_term = SUM_W'(signed'({1'b0, gains.gain_p})) * SUM_W'(err);
        i_term = SUM_W'(signed'({1'b0, gains.gain_i})) * SUM_W'(int_base);
        d_term = SUM_W'(signed'({1'b0, gains.gain_d})) * SUM_W'(err_delta);
        sum    = p_term + i_term + d_term;
    end

    // Clamp to 24 bits, scale down, add min speed less SPEED_BIAS away from zero; zero in deadband or on zero sum
    always_comb
    begin
        if (sum > SUM_W'(pidpc_pkg::SUM_MAX))
        begin
            sum_sat = 24'(pidpc_pkg::SUM_MAX);
        end
        else if (sum < SUM_W'(pidpc_pkg::SUM_MIN))
        begin
            sum_sat = 24'(pidpc_pkg::SUM_MIN);
        end
        else
        begin
            sum_sat = sum[23:0];
        end
        sum_shift = sum_sat[23:pidpc_pkg::DRIVE_SHIFT];
        speed_ofs = signed'({2'b00, gains.min_speed}) - 10'(pidpc_pkg::SPEED_BIAS);
        priority if (deadband || (sum_sat == '0))
        begin
            drive = '0;
        end
        else if (sum_sat > 0)
        begin
            drive = pidpc_pkg::DRIVE_W'(sum_shift) + pidpc_pkg::DRIVE_W'(speed_ofs);
        end
        else
        begin
            drive = pidpc_pkg::DRIVE_W'(sum_shift) - pidpc_pkg::DRIVE_W'(speed_ofs);
        end
    end

    // State holds through the deadband
    assign integral_next = deadband ? integral : int_new;
    assign last_err_next = deadband ? last_err : err;

endmodule

FILE: rtl/pid_position_controller_top.sv
// Top level of the PID position controller: config registers, input stage, output stage.
// A request accepted into the input stage reaches out_valid through the output stage register.
// Throughput: one request per cycle when out_ready is high; PID datapath sits between stages.
// State (integral, last error) updates as a request leaves the input stage; held in deadband.
// Reset (rst_n low, asynchronous): both stages empty, gains, setpoint and min speed zero,
// integral and last error zero.
`timescale 1ns / 1ps

module pid_position_controller_top #(
    parameter int POSITION_BITS = pidpc_pkg::POSITION_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [pidpc_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [POSITION_BITS-1:0]             cfg_wdata,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [POSITION_BITS-1:0]             position,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [pidpc_pkg::DRIVE_W-1:0] drive,
    output logic                                 in_deadband
);

`include "assert_macros.svh"

    pidpc_pkg::pidpc_gains_t gains_reg;
    logic [POSITION_BITS-1:0] target_reg;

    logic                     s1_valid_reg;
    logic [POSITION_BITS-1:0] pos_reg;
    logic                     out_valid_reg;
    logic signed [pidpc_pkg::DRIVE_W-1:0] drive_reg;
    logic                     deadband_reg;

    logic signed [pidpc_pkg::INT_W-1:0] integral_reg;
    logic signed [pidpc_pkg::INT_W-1:0] integral_next;
    logic signed [POSITION_BITS:0]      last_err_reg;
    logic signed [POSITION_BITS:0]      last_err_next;
    logic signed [pidpc_pkg::DRIVE_W-1:0] drive_next;
    logic                     deadband_next;
    logic                     advance;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gains_reg  <= '0;
            target_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                pidpc_pkg::REG_GAIN_P:     gains_reg.gain_p    <= cfg_wdata[7:0];
                pidpc_pkg::REG_GAIN_I:     gains_reg.gain_i    <= cfg_wdata[7:0];
                pidpc_pkg::REG_GAIN_D:     gains_reg.gain_d    <= cfg_wdata[7:0];
                pidpc_pkg::REG_TARGET_POS: target_reg          <= cfg_wdata;
                pidpc_pkg::REG_MIN_SPEED:  gains_reg.min_speed <= cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    // Stage handshake: input stage moves on when output stage is free or drained
    assign advance  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || advance;

    pidpc_core #(
        .POSITION_BITS(POSITION_BITS)
    ) u_core (
        .position     (pos_reg),
        .target       (target_reg),
        .gains        (gains_reg),
        .integral     (integral_reg),
        .last_err     (last_err_reg),
        .integral_next(integral_next),
        .last_err_next(last_err_next),
        .drive        (drive_next),
        .deadband     (deadband_next)
    );

    // Input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            pos_reg <= position;
        end
    end

    // Controller state and output stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            integral_reg  <= '0;
            last_err_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                integral_reg  <= integral_next;
                last_err_reg  <= last_err_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            drive_reg    <= drive_next;
            deadband_reg <= deadband_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign drive       = drive_reg;
    assign in_deadband = deadband_reg;

    // Checks
    `ASSERT_CLK(a_deadband_zero, (out_valid_reg && deadband_reg) |-> (drive_reg == '0), "deadband result with nonzero drive")
    `ASSERT_CLK(a_deadband_hold, (advance && deadband_next) |=> ($stable(integral_reg) && $stable(last_err_reg)), "state changed on deadband request")
    `ASSERT_NEVER(a_int_range, (integral_reg > pidpc_pkg::INT_W'(pidpc_pkg::INT_MAX)) || (integral_reg < pidpc_pkg::INT_W'(-pidpc_pkg::INT_MAX)), "integral out of clamp range")
    `ASSERT_CLK(a_ready_empty, !out_valid_reg |-> in_ready, "input stalled with empty output stage")

endmodule
